/* rtl/cpcf_pkg.sv */
// Shared types, constants and CRC helpers of the command framer.
// No dependencies; every other file of the block imports this package.
package cpcf_pkg;

    localparam int unsigned CMD_W  = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ADDR_W = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // CRC-4: poly x^4+x+1, init all ones, MSB first
    localparam logic [3:0] CRC4_POLY = 4'h3;
    localparam logic [3:0] CRC4_INIT = 4'hF;
    // CRC-8: poly 0xD5, init all ones, MSB first
    localparam logic [BYTE_W-1:0] CRC8_POLY = 8'hD5;
    localparam logic [BYTE_W-1:0] CRC8_INIT = 8'hFF;

    localparam logic [BYTE_W-1:0] LEN_NIBBLE = 8'h10;
    localparam logic [BYTE_W-1:0] NODE_MASK  = 8'hFC;
    localparam logic [BYTE_W-1:0] NODE_FLAG  = 8'h02;

    // reset values of the configuration registers
    localparam logic [ADDR_W-1:0] RST_DEVICE_ADDRESS   = 7'd108;
    localparam logic [BYTE_W-1:0] RST_COMMAND_REGISTER = 8'h00;
    localparam logic              RST_CRC_MODE         = 1'b1;
    localparam logic              RST_LOW_BYTE_FIRST   = 1'b1;

    // frame slot index, one slot per output word
    localparam int unsigned SLOT_W = 3;
    localparam logic [SLOT_W-1:0] SLOT_FIRST      = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_LAST_PLAIN = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_LAST_CRC   = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDRESS   = 2'd0,
        CFG_COMMAND_REGISTER = 2'd1,
        CFG_CRC_MODE         = 2'd2,
        CFG_LOW_BYTE_FIRST   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [ADDR_W-1:0] device_address;
        logic [BYTE_W-1:0] command_register;
        logic              crc_mode;
        logic              low_byte_first;
    } cfg_t;

    // word parked in the input stage, offered to the serializer
    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] word;
    } hold_t;

    // feed the top nbits of data, MSB first, into the CRC-4
    function automatic logic [3:0] crc4_bits(input logic [3:0] crc_in,
                                             input logic [BYTE_W-1:0] data,
                                             input int unsigned nbits);
        logic [3:0] c;
        logic       top;
        c = crc_in;
        for (int i = 0; i < BYTE_W; i++) begin
            if (i < nbits) begin
                top = c[3];
                c   = {c[2:0], 1'b0};
                if (top != data[BYTE_W-1-i]) begin
                    c = c ^ CRC4_POLY;
                end
            end
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        logic              top;
        c = crc_in;
        for (int i = 0; i < BYTE_W; i++) begin
            top = c[BYTE_W-1];
            c   = {c[BYTE_W-2:0], 1'b0};
            if (top != data[BYTE_W-1-i]) begin
                c = c ^ CRC8_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] node_byte(input logic [ADDR_W-1:0] addr);
        return ({addr, 1'b0} & NODE_MASK) | NODE_FLAG;
    endfunction

endpackage

/* rtl/cpcf_if.sv */
// Valid/ready channel interfaces: command words in, frame bytes out.
// Depends on cpcf_pkg for the payload widths.
interface cpcf_cmd_if import cpcf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command_word;

    modport source (output valid, output command_word, input ready);
    modport sink   (input valid, input command_word, output ready);
endinterface

interface cpcf_frame_if import cpcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

/* rtl/crc_protected_command_framer.sv */
// Top level of the CRC-protected command framer.
// Depends on cpcf_pkg, cpcf_if, cpcf_cfg_regs, cpcf_in_stage, cpcf_serializer.
//
//  Channel   Direction  Payload                         Handshake
//  cmd       in         command_word[15:0]              valid/ready
//  frame     out        frame_byte[7:0], last_byte      valid/ready
//  cfg       in         cfg_index[1:0], cfg_wdata[7:0]  cfg_we, no stall
//
// Frames: a frame is 5 words in CRC mode and 3 in plain mode, one per cycle
//   with frame.ready high; frames follow each other with no gap while a command
//   is parked, so the command rate is set by the byte serializer.
// Start: an accepted command waits in the input register until the serializer
//   is free to load it; the first frame byte is valid once busy is registered.
// Reset: rst_n asynchronous, active low; clears the control flags and loads
//   the register defaults (address 108, register 0, CRC mode, low byte first).
// Stalls: frame.ready low freezes the current byte; the input register still
//   takes one more command, then cmd.ready drops until that word is loaded.

module crc_protected_command_framer import cpcf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    cpcf_cmd_if.sink              cmd,
    cpcf_frame_if.source          frame,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t  cfg;
    hold_t hold;
    logic  load;

    // register file: device address, register byte, mode and byte order
    cpcf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // one-word input register; decouples cmd.ready from frame.ready
    cpcf_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .load  (load),
        .hold  (hold)
    );

    // builds the frame at load time (CRC-4 length byte, byte order) and
    // sends it out word by word while the CRC-8 runs along
    cpcf_serializer u_serializer (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .hold  (hold),
        .load  (load),
        .frame (frame)
    );

endmodule

/* rtl/cpcf_cfg_regs.sv */
// Configuration register file of the command framer, write only.
// Depends on cpcf_pkg.
module cpcf_cfg_regs import cpcf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_DEVICE_ADDRESS:   cfg_next.device_address   = cfg_wdata[ADDR_W-1:0];
                CFG_COMMAND_REGISTER: cfg_next.command_register = cfg_wdata[BYTE_W-1:0];
                CFG_CRC_MODE:         cfg_next.crc_mode         = cfg_wdata[0];
                CFG_LOW_BYTE_FIRST:   cfg_next.low_byte_first   = cfg_wdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.device_address   <= RST_DEVICE_ADDRESS;
            cfg_reg.command_register <= RST_COMMAND_REGISTER;
            cfg_reg.crc_mode         <= RST_CRC_MODE;
            cfg_reg.low_byte_first   <= RST_LOW_BYTE_FIRST;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/cpcf_in_stage.sv */
// Input register: parks one command word until the serializer loads it.
// Depends on cpcf_pkg and cpcf_cmd_if.
module cpcf_in_stage import cpcf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    cpcf_cmd_if.sink         cmd,
    input  logic             load,
    output hold_t            hold
);

    logic             full_reg;
    logic             full_next;
    logic [CMD_W-1:0] word_reg;
    logic             take;

    // ready does not look downstream: the stage frees up in the cycle after load
    assign cmd.ready = !full_reg;
    assign take      = cmd.valid && !full_reg;

    always_comb
    begin
        full_next = full_reg;
        if (take) begin
            full_next = 1'b1;
        end
        else if (load) begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
        end
        else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            word_reg <= cmd.command_word;
        end
    end

    assign hold.valid = full_reg;
    assign hold.word  = word_reg;

endmodule

/* rtl/cpcf_serializer.sv */
// Frame builder and byte serializer: loads a parked word, emits the frame,
// folds each sent byte into a running CRC-8. Depends on cpcf_pkg, cpcf_frame_if.
module cpcf_serializer import cpcf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  hold_t       hold,
    output logic        load,
    cpcf_frame_if.source frame
);

    logic [BYTE_W-1:0] byte_reg [4];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [BYTE_W-1:0] crc_reg;
    logic [BYTE_W-1:0] crc_next;
    logic              busy_reg;
    logic              busy_next;
    logic              mode_reg;

    logic [BYTE_W-1:0] cur_byte;
    logic              last;
    logic              take;
    logic              done;

    logic [BYTE_W-1:0] lo_byte;
    logic [BYTE_W-1:0] hi_byte;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [3:0]        crc4;
    logic [BYTE_W-1:0] len_byte;

    // frame contents for the word being loaded
    always_comb
    begin
        lo_byte     = hold.word[BYTE_W-1:0];
        hi_byte     = hold.word[CMD_W-1:BYTE_W];
        first_byte  = cfg.low_byte_first ? lo_byte : hi_byte;
        second_byte = cfg.low_byte_first ? hi_byte : lo_byte;
        crc4        = crc4_bits(crc4_bits(CRC4_INIT, cfg.command_register, 8),
                                LEN_NIBBLE, 4);
        len_byte    = LEN_NIBBLE | {4'h0, crc4};
    end

    always_comb
    begin
        if (mode_reg && (slot_reg == SLOT_LAST_CRC)) begin
            cur_byte = crc_reg;
        end
        else begin
            cur_byte = byte_reg[slot_reg[1:0]];
        end
        last = mode_reg ? (slot_reg == SLOT_LAST_CRC) : (slot_reg == SLOT_LAST_PLAIN);
    end

    assign take = busy_reg && frame.ready;
    assign done = take && last;
    assign load = hold.valid && (!busy_reg || done);

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        crc_next  = crc_reg;
        if (load) begin
            busy_next = 1'b1;
            slot_next = SLOT_FIRST;
            crc_next  = crc8_byte(CRC8_INIT, node_byte(cfg.device_address));
        end
        else if (done) begin
            busy_next = 1'b0;
        end
        else if (take) begin
            slot_next = slot_reg + 1'b1;
            crc_next  = crc8_byte(crc_reg, cur_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            slot_reg <= SLOT_FIRST;
            mode_reg <= RST_CRC_MODE;
        end
        else begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
            if (load) begin
                mode_reg <= cfg.crc_mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (load) begin
            byte_reg[0] <= cfg.command_register;
            if (cfg.crc_mode) begin
                byte_reg[1] <= len_byte;
                byte_reg[2] <= first_byte;
                byte_reg[3] <= second_byte;
            end
            else begin
                byte_reg[1] <= first_byte;
                byte_reg[2] <= second_byte;
                byte_reg[3] <= '0;
            end
        end
    end

    assign frame.valid      = busy_reg;
    assign frame.frame_byte = cur_byte;
    assign frame.last_byte  = last;

    a_slot_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (mode_reg ? (slot_reg <= SLOT_LAST_CRC) : (slot_reg <= SLOT_LAST_PLAIN)))
        else $error("slot index ran past the end of the frame");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!busy_reg || done))
        else $error("new frame loaded over an unfinished one");

    a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last) |=> (busy_reg && (slot_reg == $past(slot_reg) + 1'b1)))
        else $error("slot did not advance after a sent byte");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !load) |=> !busy_reg)
        else $error("serializer still busy after the last byte");

    a_fresh_frame_starts_at_first: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && (slot_reg == SLOT_FIRST)))
        else $error("loaded frame does not start at the register byte");

endmodule

/* verif/tb_crc_protected_command_framer.sv */
`timescale 1ns / 100ps
// Self-checking testbench of crc_protected_command_framer: directed and random commands.
// Depends on cpcf_pkg, cpcf_if and the framer RTL; frames are predicted here, word by word.
module tb_crc_protected_command_framer;
    import cpcf_pkg::*;

    // Longest run of cycles with no word moving on either channel before we give up.
    // The slowest correct gap is a stall burst, a command gap or a drain plus the register writes, well under this.
    localparam int QUIET_LIMIT = 500;
    // Settling time after the last frame word before touching registers or ending.
    localparam int DRAIN_PAD = 6;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_COMMANDS = 49;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last_byte;
    } frame_word_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cpcf_cmd_if   cmd_if ();
    cpcf_frame_if frame_if ();

    crc_protected_command_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .frame     (frame_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Register image as the framer should hold it, and the frame words still owed.
    cfg_t        shadow_cfg;
    frame_word_t pending_frame_words[$];
    int          error_count;
    // Random idling switches for the command sender and the frame receiver.
    bit          cmd_gaps_on;
    bit          frame_stalls_on;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Frame prediction
    // ------------------------------------------------------------------

    // MSB-first shift of the top 'count' bits of data through the CRC-4.
    function automatic logic [3:0] crc4_shift(input logic [3:0] crc,
                                              input logic [BYTE_W-1:0] data,
                                              input int count);
        logic fb;
        for (int i = 0; i < count; i++) begin
            fb  = crc[3] ^ data[BYTE_W-1-i];
            crc = {crc[2:0], 1'b0} ^ (fb ? CRC4_POLY : 4'h0);
        end
        return crc;
    endfunction

    function automatic logic [BYTE_W-1:0] crc8_shift(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
        logic fb;
        for (int i = 0; i < BYTE_W; i++) begin
            fb  = crc[BYTE_W-1] ^ data[BYTE_W-1-i];
            crc = {crc[BYTE_W-2:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
        end
        return crc;
    endfunction

    // Queue every word of the frame that one command should produce.
    function automatic void predict_frame(input logic [CMD_W-1:0] command);
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] cmd_a;
        logic [BYTE_W-1:0] cmd_b;
        logic [BYTE_W-1:0] len_crc4;
        logic [BYTE_W-1:0] node;
        logic [BYTE_W-1:0] crc8;
        logic [3:0]        crc4;
        reg_addr = shadow_cfg.command_register;
        cmd_a    = shadow_cfg.low_byte_first ? command[7:0] : command[15:8];
        cmd_b    = shadow_cfg.low_byte_first ? command[15:8] : command[7:0];
        if (!shadow_cfg.crc_mode) begin
            pending_frame_words.push_back('{frame_byte: reg_addr, last_byte: 1'b0});
            pending_frame_words.push_back('{frame_byte: cmd_a, last_byte: 1'b0});
            pending_frame_words.push_back('{frame_byte: cmd_b, last_byte: 1'b1});
        end
        else begin
            // CRC-4 runs over the register byte and the length nibble only
            crc4     = crc4_shift(CRC4_INIT, reg_addr, 8);
            crc4     = crc4_shift(crc4, LEN_NIBBLE, 4);
            len_crc4 = LEN_NIBBLE | {4'h0, crc4};
            // node byte drops address bit 0 and sets the write flag
            node     = ({shadow_cfg.device_address, 1'b0} & NODE_MASK) | NODE_FLAG;
            crc8     = crc8_shift(CRC8_INIT, node);
            crc8     = crc8_shift(crc8, reg_addr);
            crc8     = crc8_shift(crc8, len_crc4);
            crc8     = crc8_shift(crc8, cmd_a);
            crc8     = crc8_shift(crc8, cmd_b);
            pending_frame_words.push_back('{frame_byte: reg_addr, last_byte: 1'b0});
            pending_frame_words.push_back('{frame_byte: len_crc4, last_byte: 1'b0});
            pending_frame_words.push_back('{frame_byte: cmd_a, last_byte: 1'b0});
            pending_frame_words.push_back('{frame_byte: cmd_b, last_byte: 1'b0});
            pending_frame_words.push_back('{frame_byte: crc8, last_byte: 1'b1});
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one command word and hold it until taken. valid stays high on return,
    // so back-to-back calls stream with no bubble unless a gap is drawn.
    task automatic send_command(input logic [CMD_W-1:0] command);
        int gap;
        if (cmd_gaps_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 4);
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.command_word <= command;
        do @(posedge clk); while (!cmd_if.ready);
        predict_frame(command);
    endtask

    // Drop valid and wait until every owed frame word has come out.
    task automatic wait_frames_drained();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_frame_words.size() != 0) @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // One write cycle; the image follows the register, upper bits masked off.
    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEVICE_ADDRESS:   shadow_cfg.device_address   = data[ADDR_W-1:0];
            CFG_COMMAND_REGISTER: shadow_cfg.command_register = data;
            CFG_CRC_MODE:         shadow_cfg.crc_mode         = data[0];
            CFG_LOW_BYTE_FIRST:   shadow_cfg.low_byte_first   = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Registers only change with the framer idle.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] addr_data,
                                  input logic [CFG_DATA_W-1:0] reg_data,
                                  input logic [CFG_DATA_W-1:0] mode_data,
                                  input logic [CFG_DATA_W-1:0] order_data);
        wait_frames_drained();
        write_register(CFG_DEVICE_ADDRESS, addr_data);
        write_register(CFG_COMMAND_REGISTER, reg_data);
        write_register(CFG_CRC_MODE, mode_data);
        write_register(CFG_LOW_BYTE_FIRST, order_data);
    endtask

    function automatic logic [CMD_W-1:0] random_command();
        // mostly uniform, now and then an all-zero, all-one or half-and-half pattern
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h00FF;
            3:       return 16'hFF00;
            default: return CMD_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: address 108, register 0, CRC frame, low byte first.
    task automatic test_reset_defaults();
        send_command(16'h0000);
        send_command(16'hFFFF);
        send_command(16'h00FF);
        send_command(16'hFF00);
        send_command(16'h8001);
    endtask

    // High command byte first, CRC frame kept.
    task automatic test_byte_order();
        apply_settings(8'd108, 8'h00, 8'h01, 8'h00);
        send_command(16'h1234);
        send_command(16'hFF00);
    endtask

    // Three-word frame in both byte orders.
    task automatic test_plain_mode();
        apply_settings(8'd108, 8'h5A, 8'h00, 8'h01);
        send_command(16'hA55A);
        send_command(16'hFFFF);
        apply_settings(8'd108, 8'hA5, 8'h00, 8'h00);
        send_command(16'h0000);
        send_command(16'h12EF);
    endtask

    // Field extremes, and writes with bits above the register width set.
    task automatic test_register_extremes();
        apply_settings(8'hFF, 8'hFF, 8'h03, 8'hFE);
        send_command(16'hFFFF);
        send_command(16'h0001);
        apply_settings(8'h00, 8'h00, 8'h01, 8'h01);
        send_command(16'h0000);
        send_command(16'hFFFE);
        // address bit 7 masked to zero, crc_mode bit 0 clear means plain frame
        apply_settings(8'h80, 8'h80, 8'h02, 8'hFF);
        send_command(16'h7FFF);
        send_command(16'h8000);
    endtask

    // Random command phases; address and register bytes extreme in phases 0 and 1, then
    // random; mode and order follow the phase; the last phase runs with neither side idling.
    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] addr_data;
        logic [CFG_DATA_W-1:0] reg_data;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            addr_data = CFG_DATA_W'($urandom_range(0, 255));
            reg_data  = CFG_DATA_W'($urandom_range(0, 255));
            if (p == 0) begin
                addr_data = 8'h7F;
                reg_data  = 8'hFF;
            end
            else if (p == 1) begin
                addr_data = 8'h00;
                reg_data  = 8'h00;
            end
            apply_settings(addr_data, reg_data,
                           CFG_DATA_W'({$urandom_range(0, 127), 1'(p % 3 != 2)}),
                           CFG_DATA_W'({$urandom_range(0, 127), 1'(p % 2)}));
            if (p == RANDOM_PHASES - 1) begin
                cmd_gaps_on     = 1'b0;
                frame_stalls_on = 1'b0;
            end
            else begin
                cmd_gaps_on     = ($urandom_range(0, 3) != 0);
                frame_stalls_on = ($urandom_range(0, 3) != 0);
            end
            for (int n = 0; n < PHASE_COMMANDS; n++) begin
                // sender holds off mid-phase until the framer has emptied
                if (n == PHASE_COMMANDS / 2) wait_frames_drained();
                send_command(random_command());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Frame receiver and checker
    // ------------------------------------------------------------------
    initial begin : frame_checker
        frame_word_t got;
        frame_word_t want;
        int          stall_left;
        stall_left     = 0;
        frame_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && frame_if.valid && frame_if.ready) begin
                got = '{frame_byte: frame_if.frame_byte, last_byte: frame_if.last_byte};
                if (pending_frame_words.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected frame word, expected none, actual byte %h last %b",
                             $time, got.frame_byte, got.last_byte);
                end
                else begin
                    want = pending_frame_words.pop_front();
                    if (got.frame_byte !== want.frame_byte) begin
                        error_count++;
                        $display("%0t: frame_byte mismatch, expected %h actual %h",
                                 $time, want.frame_byte, got.frame_byte);
                    end
                    if (got.last_byte !== want.last_byte) begin
                        error_count++;
                        $display("%0t: last_byte mismatch, expected %b actual %b",
                                 $time, want.last_byte, got.last_byte);
                    end
                end
            end
            // ready: random stall bursts when enabled
            if (!rst_n) begin
                frame_if.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                frame_if.ready <= 1'b0;
            end
            else if (frame_stalls_on && $urandom_range(0, 3) == 0) begin
                stall_left     = $urandom_range(0, 3);
                frame_if.ready <= 1'b0;
            end
            else begin
                frame_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when no word moves for too long
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (frame_if.valid && frame_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, no word moved for %0d cycles, %0d frame words owed",
                 $time, QUIET_LIMIT, pending_frame_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        error_count         = 0;
        cmd_gaps_on         = 1'b1;
        frame_stalls_on     = 1'b1;
        shadow_cfg          = '{device_address:   RST_DEVICE_ADDRESS,
                                command_register: RST_COMMAND_REGISTER,
                                crc_mode:         RST_CRC_MODE,
                                low_byte_first:   RST_LOW_BYTE_FIRST};
        rst_n               <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.command_word <= '0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_DEVICE_ADDRESS;
        cfg_wdata           <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_byte_order();
        test_plain_mode();
        test_register_extremes();
        test_random_phases();

        // all frames out, then the drain pad to catch stray words
        wait_frames_drained();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cpcf_pkg.sv
rtl/cpcf_if.sv
rtl/cpcf_cfg_regs.sv
rtl/cpcf_in_stage.sv
rtl/cpcf_serializer.sv
rtl/crc_protected_command_framer.sv
verif/tb_crc_protected_command_framer.sv
